// ----- rtl/tsel_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tsel_pkg;

	localparam logic [1:0] OP_LOOKUP   = 2'd0;
	localparam logic [1:0] OP_WR_INDEX = 2'd1;
	localparam logic [1:0] OP_WR_WORD  = 2'd2;

	localparam int CNT_BITS     = 7;
	localparam int STEP_BITS    = CNT_BITS + 1;
	localparam int SLOT_BITS    = 9;
	localparam int WORDS_PER_BLOCK = 512;
	localparam int OFFSET_BITS  = 30;
	localparam int OFFSET_SHIFT = 12;
	localparam int VALUE_SHIFT  = 30;
	localparam int VALUE_BITS   = 34;
	localparam logic [SLOT_BITS-1:0] FIRST_PROBE = 9'd256;

	typedef struct packed {
		logic [1:0]           operation;
		logic [5:0]           block_number;
		logic [SLOT_BITS-1:0] slot;
		logic [63:0]          word;
	} in_beat_t;

	typedef struct packed {
		logic                  found;
		logic [VALUE_BITS-1:0] start_value;
	} out_beat_t;

	typedef struct packed {
		logic eq;
		logic lt;
	} probe_res_t;

endpackage

`default_nettype wire

// ----- rtl/two_level_sorted_endpoint_lookup.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Two-level sorted endpoint lookup.
// cmd beat is taken when start is high and busy is low. operation selects:
//   lookup      - search the index, then the chosen block, for cmd.word
//   write index - store cmd.word as base of entry cmd.block_number
//   write word  - store cmd.word at cmd.slot of block cmd.block_number
// Writes give no result and leave busy low.
// A lookup raises busy and ends in a one-cycle result_valid strobe with
// found and start_value (zero when not found); the receiver cannot stall.
// Each probe is a read of a synchronous RAM plus a compare. Index search:
// at most ceil(log2(n))+1 probes (n = blocks_in_use), a base re-read when
// stepping back one entry, then at most 9 block probes. busy stays high
// until the strobe, so a new lookup is not taken before the last one ends.
// A key below the first entry returns after the index search.
// cfg_valid/cfg_ready loads blocks_in_use (always ready, write only while
// idle). Reset sets blocks_in_use to 1 and clears control; the stores hold
// nothing defined until written.
module two_level_sorted_endpoint_lookup #(
	parameter int MAX_BLOCKS = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire tsel_pkg::in_beat_t                  cmd,
	output logic                                     result_valid,
	output tsel_pkg::out_beat_t                      result,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [tsel_pkg::CNT_BITS-1:0]       cfg_data
);

	localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int BDEPTH = MAX_BLOCKS * tsel_pkg::WORDS_PER_BLOCK;
	localparam int BW = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
	localparam int CB = tsel_pkg::CNT_BITS;
	localparam int SB = tsel_pkg::STEP_BITS;
	localparam int LB = tsel_pkg::SLOT_BITS;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_IX_RD    = 3'd1;
	localparam logic [2:0] ST_IX_CMP   = 3'd2;
	localparam logic [2:0] ST_BASE_RD  = 3'd3;
	localparam logic [2:0] ST_BASE_CMP = 3'd4;
	localparam logic [2:0] ST_BK_RD    = 3'd5;
	localparam logic [2:0] ST_BK_CMP   = 3'd6;

	logic [2:0]    state_q;
	logic [CB-1:0] biu_q;
	logic [CB-1:0] n_q;
	logic [CB-1:0] pos_q;
	logic [SB-1:0] step_q;
	logic [CB-1:0] blk_q;
	logic [LB-1:0] bpos_q;
	logic [LB-1:0] bstep_q;
	logic [63:0]   key_q;
	logic [63:0]   base_q;
	logic          result_valid_q;
	tsel_pkg::out_beat_t result_q;

	logic          accept;
	logic          wr_in_range;
	logic          ix_we;
	logic          bk_we;
	logic [IW-1:0] ix_raddr;
	logic [BW-1:0] bk_raddr;
	logic [63:0]   ix_rdata;
	logic [63:0]   bk_rdata;
	logic [CB-1:0] n_eff;
	logic [SB-1:0] step_init;
	tsel_pkg::probe_res_t pres;

	logic [SB-1:0] step_nx;
	logic [9:0]    up_sum;
	logic [9:0]    last_pos;
	logic [9:0]    dn_diff;
	logic [CB-1:0] ix_next;
	logic [LB-1:0] bstep_nx;

	function automatic logic [SB-1:0] ceil_pow2(input logic [CB-1:0] n);
		logic [SB-1:0] s;
		s = SB'(1);
		for (int i = 0; i < CB; i++) begin
			if ((SB'(1) << i) < SB'(n)) begin
				s = SB'(1) << (i + 1);
			end
		end
		return s;
	endfunction

	assign accept      = start && !busy;
	assign busy        = (state_q != ST_IDLE);
	assign cfg_ready   = 1'b1;
	assign wr_in_range = (32'(cmd.block_number) < MAX_BLOCKS);
	assign ix_we = accept && (cmd.operation == tsel_pkg::OP_WR_INDEX) && wr_in_range;
	assign bk_we = accept && (cmd.operation == tsel_pkg::OP_WR_WORD) && wr_in_range;

	always_comb begin
		n_eff = (biu_q == '0) ? CB'(1) : biu_q;
		if (32'(n_eff) > MAX_BLOCKS) begin
			n_eff = CB'(MAX_BLOCKS);
		end
	end
	assign step_init = ceil_pow2(n_eff);

	assign ix_raddr = (state_q == ST_BASE_RD) ? IW'(blk_q) : IW'(pos_q);
	assign bk_raddr = BW'({IW'(blk_q), bpos_q});

	tsel_ram #(.WIDTH(64), .DEPTH(MAX_BLOCKS)) u_index_ram (
		.clk   (clk),
		.we    (ix_we),
		.waddr (IW'(cmd.block_number)),
		.wdata (cmd.word),
		.raddr (ix_raddr),
		.rdata (ix_rdata)
	);

	tsel_ram #(.WIDTH(64), .DEPTH(BDEPTH)) u_block_ram (
		.clk   (clk),
		.we    (bk_we),
		.waddr (BW'({IW'(cmd.block_number), cmd.slot})),
		.wdata (cmd.word),
		.raddr (bk_raddr),
		.rdata (bk_rdata)
	);

	tsel_probe u_probe (
		.key        (key_q),
		.word       ((state_q == ST_IX_CMP) ? ix_rdata : bk_rdata),
		.base       (base_q),
		.block_mode (state_q == ST_BK_CMP),
		.res        (pres)
	);

	// index step with clamping to [0, n-1]
	assign step_nx  = step_q >> 1;
	assign up_sum   = 10'(pos_q) + 10'(step_nx);
	assign last_pos = 10'(n_q) - 10'd1;
	assign dn_diff  = 10'(pos_q) - 10'(step_nx);
	always_comb begin
		if (pres.lt) begin
			ix_next = (up_sum > last_pos) ? last_pos[CB-1:0] : up_sum[CB-1:0];
		end else begin
			ix_next = dn_diff[9] ? '0 : dn_diff[CB-1:0];
		end
	end
	assign bstep_nx = bstep_q >> 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			biu_q <= CB'(1);
		end else if (cfg_valid && cfg_ready) begin
			biu_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && (cmd.operation == tsel_pkg::OP_LOOKUP)) begin
						state_q <= ST_IX_RD;
					end
				end
				ST_IX_RD: begin
					state_q <= ST_IX_CMP;
				end
				ST_IX_CMP: begin
					if (pres.eq || (step_nx == '0 && pres.lt)) begin
						state_q <= ST_BK_RD;
					end else if (step_nx == '0) begin
						if (pos_q == '0) begin
							result_valid_q <= 1'b1;
							state_q        <= ST_IDLE;
						end else begin
							state_q <= ST_BASE_RD;
						end
					end else begin
						state_q <= ST_IX_RD;
					end
				end
				ST_BASE_RD: begin
					state_q <= ST_BASE_CMP;
				end
				ST_BASE_CMP: begin
					state_q <= ST_BK_RD;
				end
				ST_BK_RD: begin
					state_q <= ST_BK_CMP;
				end
				ST_BK_CMP: begin
					if (pres.eq || bstep_nx == '0) begin
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end else begin
						state_q <= ST_BK_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				key_q  <= cmd.word;
				n_q    <= n_eff;
				pos_q  <= n_eff >> 1;
				step_q <= step_init;
			end
			ST_IX_CMP: begin
				bpos_q  <= tsel_pkg::FIRST_PROBE;
				bstep_q <= tsel_pkg::FIRST_PROBE;
				base_q  <= ix_rdata;
				if (!pres.eq && step_nx == '0 && !pres.lt) begin
					blk_q <= pos_q - CB'(1);
				end else begin
					blk_q <= pos_q;
				end
				if (!pres.eq) begin
					step_q <= step_nx;
					if (step_nx != '0) begin
						pos_q <= ix_next;
					end
				end
				if (!pres.eq && step_nx == '0 && !pres.lt && pos_q == '0) begin
					result_q <= '0;
				end
			end
			ST_BASE_CMP: begin
				base_q <= ix_rdata;
			end
			ST_BK_CMP: begin
				if (pres.eq) begin
					result_q.found       <= 1'b1;
					result_q.start_value <=
						bk_rdata[tsel_pkg::VALUE_SHIFT +: tsel_pkg::VALUE_BITS];
				end else begin
					bstep_q <= bstep_nx;
					if (pres.lt) begin
						bpos_q <= bpos_q + bstep_nx;
					end else begin
						bpos_q <= bpos_q - bstep_nx;
					end
					if (bstep_nx == '0) begin
						result_q <= '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

// ----- rtl/tsel_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tsel_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/tsel_probe.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tsel_probe (
	input  wire logic [63:0]       key,
	input  wire logic [63:0]       word,
	input  wire logic [63:0]       base,
	input  wire logic              block_mode,
	output tsel_pkg::probe_res_t   res
);

	logic [63:0] offset;
	logic [63:0] here;

	assign offset = 64'(word[tsel_pkg::OFFSET_BITS-1:0]) << tsel_pkg::OFFSET_SHIFT;
	assign here   = block_mode ? (base + offset) : word;

	assign res.eq = (here == key);
	assign res.lt = (here < key);

endmodule

`default_nettype wire
